[hw/rtl/rce_pkg.sv]
// Shared types, constants and CRC helper for the region checksum engine.
package rce_pkg;

    localparam int DATA_W = 32;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [DATA_W-1:0] CRC_POLY    = 32'hEDB8_8320;
    localparam logic [DATA_W-1:0] CRC_RESIDUE = 32'h3501_5001;

    // Configuration register indexes
    localparam logic [1:0] CFG_IDX_ALGORITHM    = 2'd0;
    localparam logic [1:0] CFG_IDX_INIT_VALUE   = 2'd1;
    localparam logic [1:0] CFG_IDX_EXPECTED_SUM = 2'd2;

    typedef enum logic [1:0] {
        ALG_CRC32   = 2'd0,
        ALG_ADD32   = 2'd1,
        ALG_ADD16   = 2'd2,
        ALG_UNKNOWN = 2'd3
    } alg_t;

    // One classified dword on its way from front to back
    typedef struct packed {
        alg_t              alg;
        logic [DATA_W-1:0] word;
        logic [DATA_W-1:0] addend;
        logic              last;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef logic [DATA_W-1:0][DATA_W-1:0] crc_cols_t;

    // Column i: the CRC state after a full dword when only bit i of (crc ^ word) is set.
    // The dword update is linear, so any update is the XOR of the selected columns.
    function automatic crc_cols_t crc_columns();
        crc_cols_t         cols;
        logic [DATA_W-1:0] c;
        logic              fb;
        for (int i = 0; i < DATA_W; i++) begin
            c = '0;
            c[i] = 1'b1;
            for (int b = 0; b < DATA_W; b++) begin
                fb = c[0];
                c = c >> 1;
                if (fb) begin
                    c = c ^ CRC_POLY;
                end
            end
            cols[i] = c;
        end
        return cols;
    endfunction

    localparam crc_cols_t CRC_COLS = crc_columns();

endpackage

[hw/rtl/rce_front.sv]
// Front end: accepts dwords and precomputes the additive term for the back end.
module rce_front (
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rce_pkg::DATA_W-1:0]      s_tdata,   // [31:0] data_word
    input  logic                            s_tlast,   // last_word
    input  rce_pkg::alg_t                   alg,
    input  rce_pkg::q_status_t              q_status,
    output logic                            push,
    output rce_pkg::item_t                  push_item
);

    localparam int HALF_W = rce_pkg::DATA_W / 2;

    logic [HALF_W-1:0]          lo;
    logic [HALF_W-1:0]          hi;
    logic [rce_pkg::DATA_W-1:0] hi_term;

    assign s_tready = !q_status.full;
    assign push     = s_tvalid && !q_status.full;

    assign lo = s_tdata[HALF_W-1:0];
    assign hi = s_tdata[rce_pkg::DATA_W-1:HALF_W];
    // Final halfword of a region counts in the upper half
    assign hi_term = s_tlast ? {hi, {HALF_W{1'b0}}} : {{HALF_W{1'b0}}, hi};

    always_comb begin
        push_item.alg  = alg;
        push_item.word = s_tdata;
        push_item.last = s_tlast;
        case (alg)
            rce_pkg::ALG_ADD32: begin
                push_item.addend = s_tdata;
            end
            rce_pkg::ALG_ADD16: begin
                push_item.addend = {{HALF_W{1'b0}}, lo} + hi_term;
            end
            default: begin
                push_item.addend = '0;
            end
        endcase
    end

endmodule

[hw/rtl/rce_queue.sv]
// Short FIFO between front and back end.
module rce_queue #(
    parameter int DEPTH = rce_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  rce_pkg::item_t      push_item,
    input  logic                pop,
    output rce_pkg::item_t      head,
    output rce_pkg::q_status_t  status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    rce_pkg::item_t     entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign head         = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_FULL);
    assign status.empty = (count_reg == '0);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[hw/rtl/rce_back.sv]
// Back end: running CRC or sum per region and the result register.
module rce_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  rce_pkg::item_t              head,
    input  rce_pkg::q_status_t          q_status,
    output logic                        pop,
    input  logic [rce_pkg::DATA_W-1:0]  init_value,
    input  logic [rce_pkg::DATA_W-1:0]  expected_sum,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [rce_pkg::DATA_W-1:0]  m_tdata,   // [31:0] checksum
    output logic                        m_tuser    // [0] region_valid
);

    logic [rce_pkg::DATA_W-1:0] acc_reg, acc_next;
    logic                       start_reg;
    logic                       out_valid_reg;
    logic [rce_pkg::DATA_W-1:0] out_sum_reg;
    logic                       out_ok_reg;

    logic [rce_pkg::DATA_W-1:0] base;
    logic [rce_pkg::DATA_W-1:0] crc_in;
    logic [rce_pkg::DATA_W-1:0] crc_val;
    logic [rce_pkg::DATA_W-1:0] sum_val;
    logic                       ok_val;
    logic                       out_free;

    assign out_free = !out_valid_reg || m_tready;
    // Non-last dwords retire without touching the output
    assign pop = !q_status.empty && (!head.last || out_free);

    assign base   = start_reg ? init_value : acc_reg;
    assign crc_in = base ^ head.word;

    always_comb begin
        crc_val = '0;
        for (int i = 0; i < rce_pkg::DATA_W; i++) begin
            if (crc_in[i]) begin
                crc_val = crc_val ^ rce_pkg::CRC_COLS[i];
            end
        end
    end

    always_comb begin
        case (head.alg)
            rce_pkg::ALG_CRC32: begin
                acc_next = crc_val;
                sum_val  = crc_val;
                ok_val   = (crc_val == rce_pkg::CRC_RESIDUE);
            end
            rce_pkg::ALG_ADD32, rce_pkg::ALG_ADD16: begin
                acc_next = base + head.addend;
                sum_val  = acc_next;
                ok_val   = (acc_next == expected_sum);
            end
            default: begin
                acc_next = base;
                sum_val  = '0;
                ok_val   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= '0;
            start_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                acc_reg   <= acc_next;
                start_reg <= head.last;
            end
            if (pop && head.last) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && head.last) begin
            out_sum_reg <= sum_val;
            out_ok_reg  <= ok_val;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_sum_reg;
    assign m_tuser  = out_ok_reg;

endmodule

[hw/rtl/region_checksum_engine.sv]
// Top level of the region checksum engine: config registers, front, queue, back.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+----------------------------------------
//  s_       | in        | s_tvalid/s_tready  | s_tdata[31:0] data_word, s_tlast last_word
//  m_       | out       | m_tvalid/m_tready  | m_tdata[31:0] checksum, m_tuser region_valid
//  cfg_     | in        | cfg_we             | cfg_addr register index, cfg_wdata value
//
// One dword per cycle while the queue is not full; the back end's combinational CRC/adder update sets the rate.
// A result reaches m_ after its last dword is accepted, passing the queue entry and then
// the output register.
// Synchronous active-low reset clears the queue, the result valid flag and the accumulator
// and reopens a region; configuration registers reset to zero.
// A stalled output holds the back end only on a last dword; the queue (QUEUE_DEPTH entries)
// keeps accepting until full.
module region_checksum_engine #(
    parameter int QUEUE_DEPTH = rce_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [rce_pkg::DATA_W-1:0]  s_tdata,   // [31:0] data_word
    input  logic                        s_tlast,   // last_word
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [rce_pkg::DATA_W-1:0]  m_tdata,   // [31:0] checksum
    output logic [0:0]                  m_tuser,   // [0] region_valid
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_addr,
    input  logic [rce_pkg::DATA_W-1:0]  cfg_wdata
);

    rce_pkg::alg_t              alg_reg;
    logic [rce_pkg::DATA_W-1:0] init_value_reg;
    logic [rce_pkg::DATA_W-1:0] expected_sum_reg;

    logic                       push;
    rce_pkg::item_t             push_item;
    logic                       pop;
    rce_pkg::item_t             head;
    rce_pkg::q_status_t         q_status;
    logic                       region_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alg_reg          <= rce_pkg::ALG_CRC32;
            init_value_reg   <= '0;
            expected_sum_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                rce_pkg::CFG_IDX_ALGORITHM: begin
                    alg_reg <= rce_pkg::alg_t'(cfg_wdata[1:0]);
                end
                rce_pkg::CFG_IDX_INIT_VALUE: begin
                    init_value_reg <= cfg_wdata;
                end
                rce_pkg::CFG_IDX_EXPECTED_SUM: begin
                    expected_sum_reg <= cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    rce_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .alg       (alg_reg),
        .q_status  (q_status),
        .push      (push),
        .push_item (push_item)
    );

    rce_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    rce_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head         (head),
        .q_status     (q_status),
        .pop          (pop),
        .init_value   (init_value_reg),
        .expected_sum (expected_sum_reg),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (region_ok)
    );

    assign m_tuser[0] = region_ok;

    // Never pop an empty queue
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_status.empty |-> !pop)
        else $error("queue popped while empty");

    // A last dword only retires when the result register can take it
    a_last_needs_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && head.last |-> !m_tvalid || m_tready)
        else $error("result overwritten while stalled");

    // Input stalls only when the queue is full
    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> q_status.full)
        else $error("input stalled with room in queue");

    // A result needs a last dword retired in the previous cycle
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(pop && head.last))
        else $error("result without a last dword");

endmodule

[dv/region_checksum_engine_tb.sv]
// Self-checking testbench for region_checksum_engine: directed and random regions in all modes.
module region_checksum_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } dword_item_t;

    typedef struct packed {
        logic [31:0] checksum;
        logic        region_valid;
    } region_result_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_addr  = '0;
    logic [31:0] cfg_wdata = '0;

    dword_item_t    region_dwords[$];
    region_result_t expected_results[$];

    int gap_pct = 14;
    int errors = 0;
    int results_checked = 0;
    int dwords_in = 0;
    int valid_regions = 0;
    int config_phases = 0;
    int regions_by_alg[4] = '{0, 0, 0, 0};

    // stimulus-side view of the registers and the open region, used to build closing dwords
    rce_pkg::alg_t gen_alg = rce_pkg::ALG_CRC32;
    logic [31:0]   gen_init = '0;
    logic [31:0]   gen_expected = '0;
    logic [31:0]   gen_acc = '0;
    logic          gen_open = 1'b1;

    // checker-side copy of the block's registers and state
    rce_pkg::alg_t mirror_alg = rce_pkg::ALG_CRC32;
    logic [31:0]   mirror_init = '0;
    logic [31:0]   mirror_expected = '0;
    logic [31:0]   region_acc = '0;
    logic          region_open = 1'b1;

    always #5 aclk = ~aclk;

    region_checksum_engine dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // One dword folded into the running CRC or sum.
    // CRC: feeding a dword equals 32 zero-bit shifts of (crc ^ dword).
    function automatic logic [31:0] fold_dword(rce_pkg::alg_t alg, logic [31:0] acc,
                                               logic [31:0] word, logic last);
        logic [31:0] d;
        d = acc;
        case (alg)
            rce_pkg::ALG_CRC32: begin
                d = acc ^ word;
                for (int b = 0; b < 32; b++) begin
                    d = d[0] ? ((d >> 1) ^ rce_pkg::CRC_POLY) : (d >> 1);
                end
            end
            rce_pkg::ALG_ADD32: d = acc + word;
            rce_pkg::ALG_ADD16: d = acc + {16'h0, word[15:0]}
                                    + (last ? {word[31:16], 16'h0} : {16'h0, word[31:16]});
            default:            d = acc;
        endcase
        return d;
    endfunction

    // Undo 32 zero-bit CRC shifts; the top bit after a shift is the bit shifted out.
    function automatic logic [31:0] crc_unwind(logic [31:0] v);
        logic fb;
        for (int b = 0; b < 32; b++) begin
            fb = v[31];
            if (fb) begin
                v = v ^ rce_pkg::CRC_POLY;
            end
            v = {v[30:0], fb};
        end
        return v;
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(15))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h1 << $urandom_range(31);
            default: return $urandom();
        endcase
    endfunction

    // Last dword that makes the open region pass in the current mode
    function automatic logic [31:0] closing_word();
        logic [31:0] base;
        base = gen_open ? gen_init : gen_acc;
        case (gen_alg)
            rce_pkg::ALG_CRC32: return base ^ crc_unwind(rce_pkg::CRC_RESIDUE);
            rce_pkg::ALG_ADD32,
            rce_pkg::ALG_ADD16: return gen_expected - base;
            default:            return pick_word();
        endcase
    endfunction

    task automatic push_dword(logic [31:0] word, logic last);
        dword_item_t item;
        item = '{word: word, last: last};
        region_dwords.insert(region_dwords.size(), item);
        gen_acc  = fold_dword(gen_alg, gen_open ? gen_init : gen_acc, word, last);
        gen_open = last;
    endtask

    task automatic set_reg(logic [1:0] idx, logic [31:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            rce_pkg::CFG_IDX_ALGORITHM:    gen_alg = rce_pkg::alg_t'(value[1:0]);
            rce_pkg::CFG_IDX_INIT_VALUE:   gen_init = value;
            rce_pkg::CFG_IDX_EXPECTED_SUM: gen_expected = value;
            default: ;
        endcase
        @(negedge aclk);
    endtask

    // Wait until every dword is taken and every result is back, then let the pipe settle
    task automatic drain_all();
        do begin
            @(negedge aclk);
        end while (region_dwords.size() != 0 || s_tvalid || expected_results.size() != 0);
        repeat (4) @(posedge aclk);
        config_phases++;
    endtask

    always @(posedge aclk) begin : feed_driver
        dword_item_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (region_dwords.size() != 0 && $urandom_range(99) >= gap_pct) begin
                nxt = region_dwords.pop_front();
                s_tdata  <= nxt.word;
                s_tlast  <= nxt.last;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin : result_sink
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= gap_pct);
        end
    end

    // Register mirror, result check and prediction of each accepted dword
    always @(posedge aclk) begin : checksum_tracker
        region_result_t want;
        logic [31:0]    acc_next;
        if (!aresetn) begin
            mirror_alg      = rce_pkg::ALG_CRC32;
            mirror_init     = '0;
            mirror_expected = '0;
            region_acc      = '0;
            region_open     = 1'b1;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    rce_pkg::CFG_IDX_ALGORITHM:
                        mirror_alg = rce_pkg::alg_t'(cfg_wdata[1:0]);
                    rce_pkg::CFG_IDX_INIT_VALUE:   mirror_init = cfg_wdata;
                    rce_pkg::CFG_IDX_EXPECTED_SUM: mirror_expected = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result with none expected: checksum %h region_valid %b",
                           m_tdata, m_tuser[0]);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (m_tdata !== want.checksum) begin
                        $error("checksum: expected %h, got %h", want.checksum, m_tdata);
                        errors++;
                    end
                    if (m_tuser[0] !== want.region_valid) begin
                        $error("region_valid: expected %b, got %b",
                               want.region_valid, m_tuser[0]);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                dwords_in++;
                acc_next = fold_dword(mirror_alg, region_open ? mirror_init : region_acc,
                                      s_tdata, s_tlast);
                region_acc  = acc_next;
                region_open = s_tlast;
                if (s_tlast) begin
                    case (mirror_alg)
                        rce_pkg::ALG_CRC32: begin
                            want = '{checksum: acc_next,
                                     region_valid: acc_next == rce_pkg::CRC_RESIDUE};
                        end
                        rce_pkg::ALG_ADD32,
                        rce_pkg::ALG_ADD16: begin
                            want = '{checksum: acc_next,
                                     region_valid: acc_next == mirror_expected};
                        end
                        default: begin
                            want = '{checksum: '0, region_valid: 1'b0};
                        end
                    endcase
                    expected_results.insert(expected_results.size(), want);
                    regions_by_alg[int'(mirror_alg)]++;
                    if (want.region_valid) begin
                        valid_regions++;
                    end
                end
            end
        end
    end

    initial begin : stimulus
        int            phase_items;
        int            len;
        rce_pkg::alg_t alg;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset defaults: crc32 from zero; extremes and a region closing on the residue
        push_dword(32'h0000_0000, 1'b1);
        push_dword(32'hFFFF_FFFF, 1'b1);
        push_dword($urandom(), 1'b0);
        push_dword($urandom(), 1'b0);
        push_dword(closing_word(), 1'b1);
        drain_all();

        // add32 with wraparound
        set_reg(rce_pkg::CFG_IDX_ALGORITHM, 32'(rce_pkg::ALG_ADD32));
        set_reg(rce_pkg::CFG_IDX_INIT_VALUE, 32'hFFFF_FFFF);
        set_reg(rce_pkg::CFG_IDX_EXPECTED_SUM, 32'hFFFF_FFFE);
        push_dword(32'hFFFF_FFFF, 1'b1);
        push_dword(32'hFFFF_FFFF, 1'b0);
        push_dword(closing_word(), 1'b1);
        push_dword(32'h8000_0000, 1'b1);
        drain_all();

        // add16: last halfword goes in shifted up
        set_reg(rce_pkg::CFG_IDX_ALGORITHM, 32'(rce_pkg::ALG_ADD16));
        set_reg(rce_pkg::CFG_IDX_INIT_VALUE, 32'h0000_0000);
        set_reg(rce_pkg::CFG_IDX_EXPECTED_SUM, 32'hFFFF_0000);
        push_dword(32'hFFFF_FFFF, 1'b0);
        push_dword(32'hFFFF_FFFF, 1'b1);
        push_dword(32'h0000_0000, 1'b1);
        push_dword(closing_word(), 1'b1);
        drain_all();

        // unknown mode, then leave a region open across a register change
        set_reg(rce_pkg::CFG_IDX_ALGORITHM, 32'(rce_pkg::ALG_UNKNOWN));
        set_reg(rce_pkg::CFG_IDX_INIT_VALUE, 32'h5A5A_5A5A);
        push_dword(32'h1234_5678, 1'b1);
        push_dword(32'hFFFF_FFFF, 1'b0);
        push_dword(32'h0000_0000, 1'b0);
        drain_all();
        set_reg(rce_pkg::CFG_IDX_ALGORITHM, 32'(rce_pkg::ALG_CRC32));
        set_reg(rce_pkg::CFG_IDX_INIT_VALUE, 32'hFFFF_FFFF);
        push_dword(closing_word(), 1'b1);
        push_dword(32'hFFFF_FFFF, 1'b1);
        drain_all();

        for (int p = 0; p < 14; p++) begin
            alg = (p < 4) ? rce_pkg::alg_t'(p) : rce_pkg::alg_t'($urandom_range(3));
            gap_pct = (p == 6) ? 0 : 14;
            set_reg(rce_pkg::CFG_IDX_ALGORITHM, 32'(alg));
            set_reg(rce_pkg::CFG_IDX_INIT_VALUE, pick_word());
            set_reg(rce_pkg::CFG_IDX_EXPECTED_SUM, pick_word());
            phase_items = 0;
            while (phase_items < 135) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
                for (int k = 0; k < len; k++) begin
                    if (k == len - 1 && $urandom_range(1) == 1) begin
                        push_dword(closing_word(), 1'b1);
                    end else begin
                        push_dword(pick_word(), k == len - 1);
                    end
                end
                phase_items += len;
            end
            // sometimes the region stays open into the next register setting
            if ($urandom_range(2) == 0) begin
                repeat ($urandom_range(3, 1)) push_dword(pick_word(), 1'b0);
            end
            drain_all();
        end

        $display("covered %0d dwords in %0d phases", dwords_in, config_phases);
        $display("regions crc32 %0d, add32 %0d, add16 %0d, unknown %0d",
                 regions_by_alg[0], regions_by_alg[1], regions_by_alg[2], regions_by_alg[3]);
        $display("%0d results compared, %0d of them valid regions", results_checked,
                 valid_regions);
        if (errors == 0) begin
            $display("region_checksum_engine_tb: clean");
        end else begin
            $display("region_checksum_engine_tb: errors");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("timeout: %0d results still expected", expected_results.size());
        $display("region_checksum_engine_tb: errors");
        $finish;
    end

endmodule

[region_checksum_engine.f]
hw/rtl/rce_pkg.sv
hw/rtl/rce_front.sv
hw/rtl/rce_queue.sv
hw/rtl/rce_back.sv
hw/rtl/region_checksum_engine.sv
dv/region_checksum_engine_tb.sv
